// ===== rtl/trps_pkg.sv =====
package trps_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_DONE
  } state_t;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DATA_W-1:0] CORE_CLOCK_RESET = 32'd180000000;

endpackage

// ===== rtl/trps_div.sv =====
module trps_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [trps_pkg::DATA_W-1:0]     dividend,
  input  logic [trps_pkg::DATA_W-1:0]     divisor,
  output logic                            done,
  output logic [trps_pkg::DATA_W-1:0]     quotient
);

  logic                               busy_r;
  logic                               done_r;
  logic [trps_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [trps_pkg::DATA_W-1:0]        dvd_r;
  logic [trps_pkg::DATA_W-1:0]        dvs_r;
  logic [trps_pkg::DATA_W-1:0]        rem_r;
  logic [trps_pkg::DATA_W-1:0]        quo_r;
  logic [trps_pkg::DATA_W:0]          trial;
  logic                               fits;
  logic [trps_pkg::DATA_W-1:0]        rem_nxt;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial   = {rem_r, dvd_r[trps_pkg::DATA_W-1]};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? trps_pkg::DATA_W'(trial - {1'b0, dvs_r})
                   : trial[trps_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[trps_pkg::DATA_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[trps_pkg::DATA_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/timer_rate_prescaler_solver.sv =====
// An input transfer starts the bit-serial divider; the period is then halved until
// it fits the counter span, and the result is loaded. A zero rate skips straight to
// loading the result. One item is in work at a time; a new one is taken while the
// result waits. Reset (rst_n, synchronous, active low) empties the block and sets
// the core clock register to 180000000.
module timer_rate_prescaler_solver #(
  parameter longint unsigned COUNTER_SPAN = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_rate_hz,
  input  logic        in_full_clock_timer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_reload_value,
  output logic [15:0] out_prescaler_value,
  output logic        out_rate_error
);

  localparam logic [trps_pkg::DATA_W:0] SPAN_C = COUNTER_SPAN[trps_pkg::DATA_W:0];

  trps_pkg::state_t                   state_r, state_nxt;
  logic                               div_start;
  logic                               div_done;
  logic [trps_pkg::DATA_W-1:0]        core_clock_r;
  logic [trps_pkg::DATA_W-1:0]        period_r;
  logic [trps_pkg::SHIFT_W-1:0]       shift_cnt_r;
  logic                               err_r;
  logic                               out_valid_r;
  logic [trps_pkg::FIELD_W-1:0]       reload_r, reload_nxt;
  logic [trps_pkg::FIELD_W-1:0]       presc_r, presc_nxt;
  logic                               out_err_r;
  logic [trps_pkg::DATA_W-1:0]        quotient;
  logic [trps_pkg::DATA_W-1:0]        timer_clk;
  logic                               in_xfer;
  logic                               too_long;
  logic                               out_free;
  logic                               load_out;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign timer_clk = in_full_clock_timer ? core_clock_r : (core_clock_r >> 1);
  assign too_long  = ({1'b0, period_r} > SPAN_C);
  assign out_free  = !out_valid_r || out_ready;
  assign div_start = in_xfer && (in_rate_hz != '0);

  trps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (timer_clk),
    .divisor  (in_rate_hz),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trps_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_rate_hz == '0) ? trps_pkg::ST_DONE : trps_pkg::ST_DIV;
        end
      end
      trps_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = trps_pkg::ST_NORM;
        end
      end
      trps_pkg::ST_NORM: begin
        if (!too_long) begin
          state_nxt = trps_pkg::ST_DONE;
        end
      end
      trps_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = trps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      trps_pkg::ST_IDLE: in_ready = 1'b1;
      trps_pkg::ST_DONE: load_out = out_free;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (err_r) begin
      reload_nxt = '0;
      presc_nxt  = '0;
    end else begin
      if (period_r <= 32'd2) begin
        reload_nxt = 16'd1;
      end else if (period_r > 32'd65536) begin
        reload_nxt = '1;
      end else begin
        reload_nxt = trps_pkg::FIELD_W'(period_r - 32'd1);
      end
      if (shift_cnt_r >= 6'd16) begin
        presc_nxt = '1;
      end else begin
        presc_nxt = (16'd1 << shift_cnt_r[3:0]) - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= trps_pkg::ST_IDLE;
      core_clock_r <= trps_pkg::CORE_CLOCK_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        core_clock_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r       <= (in_rate_hz == '0);
      shift_cnt_r <= '0;
    end
    if (div_done) begin
      period_r <= quotient;
    end else if (state_r == trps_pkg::ST_NORM && too_long) begin
      period_r    <= period_r >> 1;
      shift_cnt_r <= shift_cnt_r + 1'b1;
    end
    if (load_out) begin
      reload_r  <= reload_nxt;
      presc_r   <= presc_nxt;
      out_err_r <= err_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_reload_value    = reload_r;
  assign out_prescaler_value = presc_r;
  assign out_rate_error      = out_err_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == trps_pkg::ST_DIV)
    else $error("Divider finished outside the divide state.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != trps_pkg::ST_IDLE)
    else $error("Input transfer did not start work.");

  a_load_fits: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (err_r || !too_long))
    else $error("Result loaded before the period was normalized.");

  a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load_out) && !out_err_r |-> out_reload_value != '0)
    else $error("Reload value of zero without a rate error.");

  a_error_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load_out) && out_err_r |-> out_reload_value == '0 && out_prescaler_value == '0)
    else $error("Rate error with nonzero result fields.");

endmodule
